>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// antecedent this cycle implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fcgi_rsp_pkg.sv
// ----------------------------------------------------------------------------
// fcgi_rsp_pkg
// Record types, phase codes and shared structs of the FastCGI response deframer.
// ----------------------------------------------------------------------------
package fcgi_rsp_pkg;

  // record types of interest
  localparam logic [7:0] KIND_END_REQUEST = 8'd3;
  localparam logic [7:0] KIND_STDOUT      = 8'd6;
  localparam logic [7:0] KIND_STDERR      = 8'd7;

  // header byte positions
  localparam logic [2:0] IDX_TYPE    = 3'd1;
  localparam logic [2:0] IDX_LEN_HI  = 3'd4;
  localparam logic [2:0] IDX_LEN_LO  = 3'd5;
  localparam logic [2:0] IDX_PAD     = 3'd6;
  localparam logic [2:0] HEADER_LAST = 3'd7;

  // record walk phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CONTENT = 2'd1;
  localparam logic [1:0] PH_PADDING = 2'd2;

  // end-of-head search progress
  localparam logic [1:0] M_NONE    = 2'd0;
  localparam logic [1:0] M_CR      = 2'd1;
  localparam logic [1:0] M_CRLF    = 2'd2;
  localparam logic [1:0] M_CRLFCR  = 2'd3;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // result kinds
  localparam logic OUT_PAYLOAD  = 1'b0;
  localparam logic OUT_COMPLETE = 1'b1;

  // per-byte decision of the record walker
  typedef struct packed {
    logic emit;       // byte is stdout/stderr content
    logic stderr;     // content belongs to stderr
    logic complete;   // end request record finished on this byte
  } walk_t;

  // one result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        stderr;
    logic        head_end;
    logic [31:0] total;
  } res_t;

endpackage

>>> rtl/fcgi_rsp_walker.sv
// ----------------------------------------------------------------------------
// fcgi_rsp_walker
// Walks record headers, content and padding; classifies every byte.
// ----------------------------------------------------------------------------
module fcgi_rsp_walker
  import fcgi_rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output walk_t      walk
);

`include "assert_macros.svh"

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] content_r, content_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic [15:0] content_dec;
  logic [7:0]  pad_dec;
  logic        rec_done;

  // next state and byte classification
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    kind_nxt    = kind_r;
    len_hi_nxt  = len_hi_r;
    content_nxt = content_r;
    pad_nxt     = pad_r;
    content_dec = content_r - 16'd1;
    pad_dec     = pad_r - 8'd1;
    rec_done    = 1'b0;
    walk        = '0;
    case (phase_r)
      PH_CONTENT: begin
        walk.emit   = (kind_r == KIND_STDOUT) || (kind_r == KIND_STDERR);
        walk.stderr = (kind_r == KIND_STDERR);
        content_nxt = content_dec;
        if (content_dec == 16'd0) begin
          if (pad_r != 8'd0) begin
            phase_nxt = PH_PADDING;
          end else begin
            rec_done = 1'b1;
          end
        end
      end
      PH_PADDING: begin
        pad_nxt = pad_dec;
        if (pad_dec == 8'd0) begin
          rec_done = 1'b1;
        end
      end
      default: begin
        case (idx_r)
          IDX_TYPE:   kind_nxt    = byte_in;
          IDX_LEN_HI: len_hi_nxt  = byte_in;
          IDX_LEN_LO: content_nxt = {len_hi_r, byte_in};
          IDX_PAD:    pad_nxt     = byte_in;
          default:    ;
        endcase
        if (idx_r == HEADER_LAST) begin
          idx_nxt = 3'd0;
          if (content_r != 16'd0) begin
            phase_nxt = PH_CONTENT;
          end else if (pad_r != 8'd0) begin
            phase_nxt = PH_PADDING;
          end else begin
            rec_done = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    endcase
    // record finished: back to header collection
    if (rec_done) begin
      phase_nxt     = PH_HEADER;
      idx_nxt       = 3'd0;
      walk.complete = (kind_r == KIND_END_REQUEST);
    end
  end

  // state registers advance once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= 3'd0;
      kind_r    <= 8'd0;
      len_hi_r  <= 8'd0;
      content_r <= 16'd0;
      pad_r     <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      kind_r    <= kind_nxt;
      len_hi_r  <= len_hi_nxt;
      content_r <= content_nxt;
      pad_r     <= pad_nxt;
    end
  end

  // content and padding phases never sit on an exhausted count
  `ASSERT_CLK(a_content_nonzero, clk, rst_n, (phase_r == PH_CONTENT) |-> (content_r != 16'd0))
  `ASSERT_CLK(a_padding_nonzero, clk, rst_n, (phase_r == PH_PADDING) |-> (pad_r != 8'd0))
  `ASSERT_CLK(a_index_in_header, clk, rst_n, (idx_r != 3'd0) |-> (phase_r == PH_HEADER))

endmodule

>>> rtl/fcgi_rsp_tracker.sv
// ----------------------------------------------------------------------------
// fcgi_rsp_tracker
// Payload count, end-of-head search and result formatting.
// ----------------------------------------------------------------------------
module fcgi_rsp_tracker
  import fcgi_rsp_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  walk_t      walk,
  output logic       res_valid,
  output res_t       res
);

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc, rep_src;
  logic [1:0]             match_r, match_nxt;
  logic                   found_r, found_nxt;
  logic                   hit;
  logic [31:0]            rep32;

  // saturating increment
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + COUNT_WIDTH'(1);

  // search, count and clear on completion
  always_comb begin
    match_nxt = match_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    hit       = 1'b0;
    if (walk.emit) begin
      if (!found_r) begin
        if (byte_in == BYTE_CR) begin
          match_nxt = (match_r == M_CRLF) ? M_CRLFCR : M_CR;
        end else if (byte_in == BYTE_LF) begin
          if (match_r == M_CR) begin
            match_nxt = M_CRLF;
          end else if (match_r == M_CRLFCR) begin
            match_nxt = M_NONE;
            found_nxt = 1'b1;
            hit       = 1'b1;
          end else begin
            match_nxt = M_NONE;
          end
        end else begin
          match_nxt = M_NONE;
        end
      end
      cnt_nxt = cnt_inc;
    end
    if (walk.complete) begin
      cnt_nxt   = '0;
      match_nxt = M_NONE;
      found_nxt = 1'b0;
    end
  end

  // reported count, limited to 32 bits
  assign rep_src = walk.emit ? cnt_inc : cnt_r;

  if (COUNT_WIDTH > 32) begin : g_wide
    assign rep32 = (|rep_src[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : rep_src[31:0];
  end else if (COUNT_WIDTH == 32) begin : g_exact
    assign rep32 = rep_src;
  end else begin : g_narrow
    assign rep32 = {{(32-COUNT_WIDTH){1'b0}}, rep_src};
  end

  // result formatting
  always_comb begin
    res_valid    = walk.emit | walk.complete;
    res.kind     = walk.complete ? OUT_COMPLETE : OUT_PAYLOAD;
    res.data     = walk.emit ? byte_in : 8'd0;
    res.stderr   = walk.emit & walk.stderr;
    res.head_end = hit;
    res.total    = rep32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      match_r <= M_NONE;
      found_r <= 1'b0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      match_r <= match_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

>>> rtl/fcgi_rsp_out_buf.sv
// ----------------------------------------------------------------------------
// fcgi_rsp_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module fcgi_rsp_out_buf
  import fcgi_rsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

`include "assert_macros.svh"

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_data_r;
  res_t skid_data_r;
  logic slot_free;

  // upstream stalls only when the skid slot is occupied
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  `ASSERT_CLK(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `ASSERT_CLK(a_no_push_when_full, clk, rst_n, push |-> !skid_valid_r)
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, out_valid_r && !out_ready && push, skid_valid_r)

endmodule

>>> rtl/fastcgi_response_deframer.sv
// ----------------------------------------------------------------------------
// fastcgi_response_deframer
// FastCGI response deframer: stdout/stderr payload extraction per byte.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock unless stalled. Every byte is decoded in
// the cycle it is accepted (record walker plus payload tracker) and its
// result, if any, appears on the out_ channel from an output register. A
// skid register behind it lets input continue for one more result while the
// output is stalled, so in_ready drops only when two results are waiting.
// Header and padding bytes and content of other record types produce no
// transaction; an end request record produces one completion transaction.
module fastcgi_response_deframer
  import fcgi_rsp_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_from_stderr,
  output logic        out_head_end_here,
  output logic [31:0] out_total_bytes
);

  logic  step;
  logic  space;
  walk_t walk;
  logic  res_valid;
  res_t  res;
  res_t  out_data;

  assign in_ready = space;
  assign step     = in_valid && space;

  // record walker
  fcgi_rsp_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_stream_byte),
    .walk    (walk)
  );

  // payload count and head search
  fcgi_rsp_tracker #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_stream_byte),
    .walk      (walk),
    .res_valid (res_valid),
    .res       (res)
  );

  // result registers
  fcgi_rsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_payload_byte  = out_data.data;
  assign out_from_stderr   = out_data.stderr;
  assign out_head_end_here = out_data.head_end;
  assign out_total_bytes   = out_data.total;

endmodule
